[rtl/rrlr_pkg.sv]
// ----------------------------------------------------------------------------
// rrlr_pkg
// Shared constants, word types and controller/datapath interface structs for
// the RSSI ring log.
// ----------------------------------------------------------------------------
package rrlr_pkg;

   localparam int DEPTH    = 32;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int RSSI_W   = 8;
   localparam int MAC_W    = 48;
   localparam int ID_W     = 16;
   localparam logic [ID_W-1:0] ID_MAX = ID_W'(65000);

   localparam logic MODE_CAPTURE = 1'b0;
   localparam logic MODE_QUERY   = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic signed [RSSI_W-1:0] rssi;
      logic        [MAC_W-1:0]  source_mac;
      logic        [ID_W-1:0]   resume_id;
   } req_word_type;

   typedef struct packed {
      logic                     has_record;
      logic signed [RSSI_W-1:0] rec_rssi;
      logic        [MAC_W-1:0]  rec_mac;
      logic        [ID_W-1:0]   rec_id;
      logic                     interrupted;
      logic                     last;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic query_start;
      logic scan_step;
      logic plan;
      logic emit_rd;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
      logic last_rec;
   } ctrl_stat_type;

endpackage

[rtl/rssi_ring_log_with_resume.sv]
// ----------------------------------------------------------------------------
// rssi_ring_log_with_resume
// Ring log of captured RSSI/MAC records tagged with sequence ids, answering
// queries from the oldest record or resuming at a given id.
// ----------------------------------------------------------------------------
// Capture: the next word is accepted on the following cycle.
// Query: an id scan over the stored records (stops at the first match), then
//   answer planning, then for each result word a registered store read and a
//   load into the output register; no new word is accepted until the last loads.
// The last result word sits in the output register while the next word is taken.
// Reset is synchronous: ring index and record count clear, next id is 1, the
//   record store itself is not cleared and no clearing pass runs.
module rssi_ring_log_with_resume (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rrlr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrlr_pkg::rsp_word_type rsp_word
);
   import rrlr_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   rrlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_word.mode),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrlr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

[rtl/rrlr_ctrl.sv]
// ----------------------------------------------------------------------------
// rrlr_ctrl
// Sequencer for the RSSI ring log: accepts a word, runs the id scan, plans the
// answer and steps the record reads and result loads.
// ----------------------------------------------------------------------------
module rrlr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   output logic                   req_stall,
   input  rrlr_pkg::ctrl_stat_type stat,
   output rrlr_pkg::ctrl_cmd_type  cmd
);
   import rrlr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_PLAN = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_LOAD = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_mode == MODE_QUERY) begin
                  cmd.query_start = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  cmd.capture = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_PLAN;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = stat.last_rec ? ST_IDLE : ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> stat.out_free)
      else $error("result loaded while output register busy");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> !$past(cmd.capture || cmd.query_start))
      else $error("word accepted outside idle");

endmodule

[rtl/rrlr_dp.sv]
// ----------------------------------------------------------------------------
// rrlr_dp
// Datapath for the RSSI ring log: record store, ring pointers, id scan,
// answer planning and the result output register.
// ----------------------------------------------------------------------------
module rrlr_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rrlr_pkg::ctrl_cmd_type  cmd,
   output rrlr_pkg::ctrl_stat_type stat,
   input  rrlr_pkg::req_word_type  req_word,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output rrlr_pkg::rsp_word_type  rsp_word
);
   import rrlr_pkg::*;

   typedef struct packed {
      logic signed [RSSI_W-1:0] rssi;
      logic        [MAC_W-1:0]  mac;
      logic        [ID_W-1:0]   id;
   } rec_word_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rec_word_type store_mem [DEPTH];
   rec_word_type rd_data_ff;
   rec_word_type wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   logic             wr_en;

   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [CNT_W-1:0] record_count_ff, record_count_in;
   logic [ID_W-1:0]  next_id_ff, next_id_in;
   logic [ID_W-1:0]  resume_id_ff, resume_id_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_pos_ff, chk_pos_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_pos_ff, found_pos_in;
   logic             intr_ff, intr_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             keep;
   logic             full;
   logic [CNT_W:0]   span;

   assign keep = (req_word.rssi != '0) && (req_word.source_mac != '0);
   assign full = (record_count_ff == FULL_CNT);
   assign wr_en = cmd.capture && keep;
   assign wr_data = '{rssi: req_word.rssi, mac: req_word.source_mac, id: next_id_ff};
   assign rd_en = cmd.scan_step || cmd.emit_rd;
   assign rd_addr = cmd.scan_step ? ptr_ff[IDX_W-1:0] : pos_ff;

   always_comb begin
      if (write_index_ff > found_pos_ff) begin
         span = (CNT_W+1)'(write_index_ff) - (CNT_W+1)'(found_pos_ff);
      end else begin
         span = (CNT_W+1)'(write_index_ff) + (CNT_W+1)'(DEPTH)
              - (CNT_W+1)'(found_pos_ff);
      end
   end

   assign stat.scan_done = found_ff || (resume_id_ff == '0)
                        || (!chk_vld_ff && (ptr_ff >= record_count_ff));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.last_rec  = (remain_ff <= CNT_W'(1));

   always_comb begin
      write_index_in  = write_index_ff;
      record_count_in = record_count_ff;
      next_id_in      = next_id_ff;
      resume_id_in    = resume_id_ff;
      ptr_in          = ptr_ff;
      chk_vld_in      = 1'b0;
      chk_pos_in      = chk_pos_ff;
      found_in        = found_ff;
      found_pos_in    = found_pos_ff;
      intr_in         = intr_ff;
      pos_in          = pos_ff;
      remain_in       = remain_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_word_in     = rsp_word_ff;

      if (wr_en) begin
         write_index_in  = (write_index_ff == LAST_IDX) ? '0 : write_index_ff + 1'b1;
         record_count_in = full ? record_count_ff : record_count_ff + 1'b1;
         next_id_in      = (next_id_ff == ID_MAX) ? ID_W'(1) : next_id_ff + 1'b1;
      end

      if (chk_vld_ff && !found_ff && (rd_data_ff.id == resume_id_ff)) begin
         found_in     = 1'b1;
         found_pos_in = chk_pos_ff;
      end

      if (cmd.query_start) begin
         resume_id_in = req_word.resume_id;
         ptr_in       = '0;
         found_in     = 1'b0;
      end

      if (cmd.scan_step) begin
         chk_vld_in = (ptr_ff < record_count_ff);
         chk_pos_in = ptr_ff[IDX_W-1:0];
         if (ptr_ff < record_count_ff) begin
            ptr_in = ptr_ff + 1'b1;
         end
      end

      if (cmd.plan) begin
         intr_in = (resume_id_ff != '0) && !found_ff;
         if (found_ff) begin
            pos_in = found_pos_ff;
            if (!full) begin
               remain_in = record_count_ff - CNT_W'(found_pos_ff);
            end else begin
               remain_in = span[CNT_W-1:0];
            end
         end else begin
            pos_in    = full ? write_index_ff : '0;
            remain_in = record_count_ff;
         end
      end

      if (cmd.load) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.has_record  = (remain_ff != '0);
         rsp_word_in.interrupted = intr_ff;
         rsp_word_in.last        = stat.last_rec;
         if (remain_ff != '0) begin
            rsp_word_in.rec_rssi = rd_data_ff.rssi;
            rsp_word_in.rec_mac  = rd_data_ff.mac;
            rsp_word_in.rec_id   = rd_data_ff.id;
            remain_in            = remain_ff - 1'b1;
            pos_in               = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
         end else begin
            rsp_word_in.rec_rssi = '0;
            rsp_word_in.rec_mac  = '0;
            rsp_word_in.rec_id   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[write_index_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff  <= '0;
         record_count_ff <= '0;
         next_id_ff      <= ID_W'(1);
         chk_vld_ff      <= 1'b0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         write_index_ff  <= write_index_in;
         record_count_ff <= record_count_in;
         next_id_ff      <= next_id_in;
         chk_vld_ff      <= chk_vld_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      resume_id_ff <= resume_id_in;
      ptr_ff       <= ptr_in;
      chk_pos_ff   <= chk_pos_in;
      found_pos_ff <= found_pos_in;
      intr_ff      <= intr_in;
      pos_ff       <= pos_in;
      remain_ff    <= remain_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      record_count_ff <= FULL_CNT)
      else $error("record count above depth");

   a_id_range: assert property (@(posedge clock) disable iff (reset)
      (next_id_ff != '0) && (next_id_ff <= ID_MAX))
      else $error("next id out of range");

   a_found_stored: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (CNT_W'(found_pos_ff) < record_count_ff))
      else $error("found position beyond stored records");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && (remain_ff == '0)) |=> (rsp_valid_ff && rsp_word_ff.last))
      else $error("empty answer not marked last");

endmodule

[dv/rrlr_check_pkg.sv]
// ----------------------------------------------------------------------------
// rrlr_check_pkg
// Scoreboard for the RSSI ring log: keeps its own copy of the record ring,
// predicts every answer word of a query and checks the words coming back.
// ----------------------------------------------------------------------------
package rrlr_check_pkg;

   import rrlr_pkg::*;

   class ring_log_board;

      logic signed [RSSI_W-1:0] rssi_mem [DEPTH];
      logic        [MAC_W-1:0]  mac_mem  [DEPTH];
      logic        [ID_W-1:0]   id_mem   [DEPTH];
      int                       write_idx;
      int                       stored;
      logic        [ID_W-1:0]   next_id;
      rsp_word_type             pending_answers [$];
      int                       errors;

      function new();
         write_idx = 0;
         stored    = 0;
         next_id   = 1;
         errors    = 0;
      endfunction

      function void note_request(req_word_type w);
         int           hit;
         int           pos;
         int           n;
         logic         intr;
         rsp_word_type r;
         if (w.mode == MODE_CAPTURE) begin
            if (w.rssi != 0 && w.source_mac != 0) begin
               rssi_mem[write_idx] = w.rssi;
               mac_mem[write_idx]  = w.source_mac;
               id_mem[write_idx]   = next_id;
               next_id   = (next_id < ID_MAX) ? next_id + 1'b1 : ID_W'(1);
               write_idx = (write_idx == DEPTH - 1) ? 0 : write_idx + 1;
               if (stored < DEPTH) stored++;
            end
            return;
         end
         hit = -1;
         if (w.resume_id != 0) begin
            for (int i = 0; i < stored; i++) begin
               if (id_mem[i] == w.resume_id) begin
                  hit = i;
                  break;
               end
            end
         end
         intr = (w.resume_id != 0) && (hit < 0);
         if (hit >= 0) begin
            pos = hit;
            if (stored < DEPTH) begin
               n = stored - hit;
            end else begin
               n = (write_idx + DEPTH - hit) % DEPTH;
               if (n == 0) n = DEPTH;
            end
         end else begin
            pos = (stored < DEPTH) ? 0 : write_idx;
            n   = stored;
         end
         if (n == 0) begin
            r             = '0;
            r.interrupted = intr;
            r.last        = 1'b1;
            pending_answers.push_back(r);
            return;
         end
         for (int k = 0; k < n; k++) begin
            r.has_record  = 1'b1;
            r.rec_rssi    = rssi_mem[pos];
            r.rec_mac     = mac_mem[pos];
            r.rec_id      = id_mem[pos];
            r.interrupted = intr;
            r.last        = (k == n - 1);
            pending_answers.push_back(r);
            pos = (pos + 1) % DEPTH;
         end
      endfunction

      function void match(string field, longint want, longint got);
         if (want != got) begin
            $error("%s expected %0d got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_answer(rsp_word_type got);
         rsp_word_type want;
         if (pending_answers.size() == 0) begin
            $error("answer word with nothing pending: id %0d", got.rec_id);
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         match("has_record", want.has_record, got.has_record);
         match("rec_rssi", want.rec_rssi, got.rec_rssi);
         match("rec_mac", want.rec_mac, got.rec_mac);
         match("rec_id", want.rec_id, got.rec_id);
         match("interrupted", want.interrupted, got.interrupted);
         match("last", want.last, got.last);
      endfunction

      function logic [ID_W-1:0] random_stored_id();
         if (stored == 0) return '0;
         return id_mem[$urandom_range(0, stored - 1)];
      endfunction

      // capture_pct: share of well-formed captures; a few dropped captures
      // follow, the rest are queries.
      function req_word_type random_word(int capture_pct);
         req_word_type w;
         int           pick;
         w.mode       = MODE_CAPTURE;
         w.rssi       = RSSI_W'($urandom);
         w.source_mac = MAC_W'({$urandom, $urandom});
         w.resume_id  = ID_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < capture_pct) begin
            if (w.rssi == 0) w.rssi = 1;
            if (w.source_mac == 0) w.source_mac = 1;
         end else if (pick < capture_pct + 7) begin
            if ($urandom_range(0, 1)) w.rssi = 0;
            else w.source_mac = 0;
         end else begin
            w.mode = MODE_QUERY;
            pick = $urandom_range(0, 99);
            if (pick < 20) w.resume_id = 0;
            else if (pick < 65) w.resume_id = random_stored_id();
         end
         return w;
      endfunction

   endclass

endpackage

[dv/tb_rssi_ring_log_with_resume.sv]
// ----------------------------------------------------------------------------
// tb_rssi_ring_log_with_resume
// Drives captures and queries into the ring log with bursty input and a
// stalling receiver, wraps the record ring, and checks every answer word
// against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_rssi_ring_log_with_resume;

   timeunit 1ns;
   timeprecision 1ps;

   import rrlr_pkg::*;
   import rrlr_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 115;
   localparam int DRAIN_CYCLES   = 3 * DEPTH + 8;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   ring_log_board board;
   int            idle_cycles = 0;
   int            stall_mode  = 0;
   int            stall_left  = 0;

   rssi_ring_log_with_resume dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic push_word(input req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      board.note_request(w);
   endtask

   task automatic rest(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic req_word_type make_word(logic mode, logic signed [RSSI_W-1:0] rssi,
                                              logic [MAC_W-1:0] mac, logic [ID_W-1:0] sid);
      req_word_type w;
      w.mode       = mode;
      w.rssi       = rssi;
      w.source_mac = mac;
      w.resume_id  = sid;
      return w;
   endfunction

   task automatic push_query(input logic [ID_W-1:0] sid);
      push_word(make_word(MODE_QUERY, RSSI_W'($urandom_range(1, 255)),
                          MAC_W'({$urandom, $urandom}), sid));
      rest($urandom_range(0, 3));
   endtask

   task automatic push_capture(input logic signed [RSSI_W-1:0] rssi,
                               input logic [MAC_W-1:0] mac);
      push_word(make_word(MODE_CAPTURE, rssi, mac, ID_W'($urandom)));
      rest($urandom_range(0, 3));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(16, 160);
         rsp_stall  <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_answer(rsp_word);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_word_type w;
      int           counted;
      int           burst;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      push_query(0);
      push_query(7);
      push_query(16'hFFFF);
      push_capture(0, 48'h1234_5678_9ABC);
      push_capture(5, 48'h0);
      push_capture(-128, 48'hFFFF_FFFF_FFFF);
      push_capture(127, 48'h1);
      push_capture(-1, 48'h8000_0000_0000);
      push_capture(1, 48'h5555_5555_5555);
      push_query(0);
      push_query(3);
      push_query(1);
      push_query(4);
      push_query(100);
      push_query(16'd65001);

      // wrap the ring with back-to-back captures
      repeat (DEPTH + 4) push_word(board.random_word(100));
      rest(2);

      push_query(0);
      push_query(board.id_mem[board.write_idx]);
      push_query(board.id_mem[(board.write_idx + DEPTH - 1) % DEPTH]);
      push_query(board.id_mem[(board.write_idx + DEPTH / 2) % DEPTH]);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst && counted < RANDOM_ITEMS; k++) begin
            w = board.random_word(45);
            push_word(w);
            counted++;
         end
         if ($urandom_range(0, 9) < 3) rest(0);
         else rest($urandom_range(1, 12));
      end
      req_valid <= 1'b0;

      while (board.pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.pending_answers.size() != 0) begin
         $error("%0d answer words never arrived", board.pending_answers.size());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rrlr_pkg.sv
rtl/rrlr_ctrl.sv
rtl/rrlr_dp.sv
rtl/rssi_ring_log_with_resume.sv
dv/rrlr_check_pkg.sv
dv/tb_rssi_ring_log_with_resume.sv
